// File: rtl/tkhq_pkg.sv
package tkhq_pkg;

    localparam int KEEP_BITS  = 9;
    localparam int POS_BITS   = 8;
    localparam int COUNT_BITS = 9;
    localparam int CNT_W      = COUNT_BITS + 1;

    localparam logic [KEEP_BITS-1:0] KEEP_RESET = 9'd256;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_KEPT       = 2'd0,
        STAT_DROPPED    = 2'd1,
        STAT_READ_OK    = 2'd2,
        STAT_READ_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_ROOT,
        S_UP_RD,
        S_UP_CMP,
        S_UP_DONE,
        S_DN_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_RESULT
    } state_t;

    typedef struct packed {
        status_t                 status;
        logic [COUNT_BITS-1:0]   held_count;
    } res_ctl_t;

    // A limit of zero acts as one, and a limit above the heap depth acts as the depth.
    function automatic int eff_limit(input logic [KEEP_BITS-1:0] keep, input int depth);
        int k;
        k = int'(keep);
        if (k == 0) begin
            k = 1;
        end else if (k > depth) begin
            k = depth;
        end
        return k;
    endfunction

endpackage

// File: rtl/top_k_min_heap_queue.sv
// Keeps the keep_count highest-scoring (score, payload) pairs in a binary min-heap held
// in one single-port-read RAM, so the lowest kept score sits in slot 0. Each word on the
// s_ side is an insert or a read of one heap slot, and each gives exactly one word on the
// m_ side. Words are processed one at a time; the next word is accepted while the previous
// result still waits in the output register. A read fetches its slot and an out-of-range
// read skips the RAM. An insert into a full heap first reads the root and is discarded
// when its score is below it; otherwise the insert sifts up from the next free slot, and
// when the heap was full the root is then removed: the last slot is moved up and sifted
// down. The heap RAM's single read port means each sift-up level needs one parent read
// and each sift-down level needs separate reads of the two children. The RAM needs no
// clearing after reset, since only slots below the held count are ever read.
module top_k_min_heap_queue #(
    parameter int HEAP_DEPTH   = 256,
    parameter int SCORE_BITS   = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic signed [SCORE_BITS-1:0]         s_score_in,
    input  logic [PAYLOAD_BITS-1:0]              s_payload_in,
    input  logic [tkhq_pkg::POS_BITS-1:0]        s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SCORE_BITS-1:0]         m_score_out,
    output logic [PAYLOAD_BITS-1:0]              m_payload_out,
    output logic [tkhq_pkg::COUNT_BITS-1:0]      m_held_count,
    output logic [1:0]                           m_status,
    input  logic                                 cfg_wr_en,
    input  logic [tkhq_pkg::KEEP_BITS-1:0]       cfg_wr_data
);

    logic [tkhq_pkg::KEEP_BITS-1:0]   keep_count_reg, keep_count_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [SCORE_BITS-1:0]     out_score_reg, out_score_next;
    logic [PAYLOAD_BITS-1:0]          out_payload_reg, out_payload_next;
    tkhq_pkg::res_ctl_t               out_ctl_reg, out_ctl_next;

    logic                             eng_valid;
    logic                             eng_ready;
    tkhq_pkg::res_ctl_t               eng_ctl;
    logic signed [SCORE_BITS-1:0]     eng_score;
    logic [PAYLOAD_BITS-1:0]          eng_payload;
    logic [tkhq_pkg::CNT_W-1:0]       limit_now;

    tkhq_engine #(
        .HEAP_DEPTH   (HEAP_DEPTH),
        .SCORE_BITS   (SCORE_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_op       (s_operation),
        .in_score    (s_score_in),
        .in_payload  (s_payload_in),
        .in_pos      (s_position),
        .keep_count  (keep_count_reg),
        .res_valid   (eng_valid),
        .res_ready   (eng_ready),
        .res_ctl     (eng_ctl),
        .res_score   (eng_score),
        .res_payload (eng_payload)
    );

    assign eng_ready = !out_valid_reg || m_ready;
    assign limit_now = tkhq_pkg::CNT_W'(tkhq_pkg::eff_limit(keep_count_reg, HEAP_DEPTH));

    always_comb begin
        keep_count_next  = cfg_wr_en ? cfg_wr_data : keep_count_reg;
        out_valid_next   = out_valid_reg;
        out_score_next   = out_score_reg;
        out_payload_next = out_payload_reg;
        out_ctl_next     = out_ctl_reg;
        if (eng_ready) begin
            out_valid_next = eng_valid;
            if (eng_valid) begin
                out_score_next   = eng_score;
                out_payload_next = eng_payload;
                out_ctl_next     = eng_ctl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= tkhq_pkg::KEEP_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            keep_count_reg <= keep_count_next;
            out_valid_reg  <= out_valid_next;
        end
        out_score_reg   <= out_score_next;
        out_payload_reg <= out_payload_next;
        out_ctl_reg     <= out_ctl_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_score_out   = out_score_reg;
    assign m_payload_out = out_payload_reg;
    assign m_held_count  = out_ctl_reg.held_count;
    assign m_status      = out_ctl_reg.status;

    // A result handed over by the engine must appear on the output in the next cycle.
    a_handover: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_valid && eng_ready |=> m_valid)
        else $error("engine result was not registered for output");

    // A discarded insert only happens on a full heap.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == tkhq_pkg::STAT_DROPPED)
        |-> ({1'b0, m_held_count} == limit_now))
        else $error("insert discarded while the heap was not full");

    // A kept insert leaves a nonempty heap within the limit.
    a_kept_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == tkhq_pkg::STAT_KEPT)
        |-> (m_held_count != '0) && ({1'b0, m_held_count} <= limit_now))
        else $error("held count out of bounds after a kept insert");

    // Inserts and out-of-range reads never return slot data.
    a_insert_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == tkhq_pkg::STAT_KEPT) || (m_status == tkhq_pkg::STAT_DROPPED)
                    || (m_status == tkhq_pkg::STAT_READ_RANGE))
        |-> (m_score_out == '0) && (m_payload_out == '0))
        else $error("nonzero slot data on a result without a valid read");

endmodule

// File: rtl/tkhq_ram.sv
module tkhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/tkhq_engine.sv
module tkhq_engine #(
    parameter int HEAP_DEPTH   = 256,
    parameter int SCORE_BITS   = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_op,
    input  logic signed [SCORE_BITS-1:0]         in_score,
    input  logic [PAYLOAD_BITS-1:0]              in_payload,
    input  logic [tkhq_pkg::POS_BITS-1:0]        in_pos,
    input  logic [tkhq_pkg::KEEP_BITS-1:0]       keep_count,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output tkhq_pkg::res_ctl_t                   res_ctl,
    output logic signed [SCORE_BITS-1:0]         res_score,
    output logic [PAYLOAD_BITS-1:0]              res_payload
);

    localparam int AW    = $clog2(HEAP_DEPTH + 1);
    localparam int DW    = SCORE_BITS + PAYLOAD_BITS;
    localparam int CW    = tkhq_pkg::CNT_W;
    localparam int XW    = (AW + 1 > CW) ? AW + 1 : CW;

    tkhq_pkg::state_t state_reg, state_next;

    logic signed [SCORE_BITS-1:0]  mv_score_reg, mv_score_next;
    logic [PAYLOAD_BITS-1:0]       mv_payload_reg, mv_payload_next;
    logic signed [SCORE_BITS-1:0]  left_score_reg, left_score_next;
    logic [PAYLOAD_BITS-1:0]       left_payload_reg, left_payload_next;
    logic [AW-1:0]                 cur_reg, cur_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    tkhq_pkg::status_t             stat_reg, stat_next;
    logic signed [SCORE_BITS-1:0]  rscore_reg, rscore_next;
    logic [PAYLOAD_BITS-1:0]       rpayload_reg, rpayload_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [DW-1:0]                 ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [DW-1:0]                 ram_rdata;

    logic signed [SCORE_BITS-1:0]  rd_score;
    logic [PAYLOAD_BITS-1:0]       rd_payload;
    logic [CW-1:0]                 k_lim;
    logic [CW-1:0]                 cnt_eff;
    logic                          pos_ok;
    logic [AW-1:0]                 parent_idx;
    logic [XW-1:0]                 l_idx;
    logic [XW-1:0]                 r_idx;
    logic                          l_ok;
    logic                          r_ok;
    logic                          pick_right;
    logic signed [SCORE_BITS-1:0]  sm_score;
    logic [PAYLOAD_BITS-1:0]       sm_payload;
    logic                          accept;

    tkhq_ram #(
        .WIDTH (DW),
        .DEPTH (HEAP_DEPTH + 1)
    ) u_heap_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_score   = $signed(ram_rdata[DW-1 -: SCORE_BITS]);
    assign rd_payload = ram_rdata[PAYLOAD_BITS-1:0];

    assign k_lim   = CW'(tkhq_pkg::eff_limit(keep_count, HEAP_DEPTH));
    assign cnt_eff = (cnt_reg > k_lim) ? k_lim : cnt_reg;
    assign pos_ok  = ({{(CW - tkhq_pkg::POS_BITS){1'b0}}, in_pos} < cnt_reg)
                     && (int'(in_pos) < HEAP_DEPTH);

    assign parent_idx = (cur_reg - AW'(1)) >> 1;
    assign l_idx      = (XW'(cur_reg) << 1) + XW'(1);
    assign r_idx      = l_idx + XW'(1);
    assign l_ok       = l_idx < XW'(cnt_reg);
    assign r_ok       = r_idx < XW'(cnt_reg);

    // On equal children the right child is taken.
    assign pick_right = r_ok && !(left_score_reg < rd_score);
    assign sm_score   = pick_right ? rd_score : left_score_reg;
    assign sm_payload = pick_right ? rd_payload : left_payload_reg;

    assign accept   = in_valid && (state_reg == tkhq_pkg::S_IDLE);
    assign in_ready = (state_reg == tkhq_pkg::S_IDLE);

    assign res_valid          = (state_reg == tkhq_pkg::S_RESULT);
    assign res_ctl.status     = stat_reg;
    assign res_ctl.held_count = tkhq_pkg::COUNT_BITS'(cnt_reg);
    assign res_score          = rscore_reg;
    assign res_payload        = rpayload_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tkhq_pkg::S_IDLE: begin
                if (in_valid) begin
                    if (in_op == tkhq_pkg::OP_READ) begin
                        state_next = pos_ok ? tkhq_pkg::S_RD_WAIT : tkhq_pkg::S_RESULT;
                    end else begin
                        state_next = (cnt_eff >= k_lim) ? tkhq_pkg::S_ROOT
                                                        : tkhq_pkg::S_UP_RD;
                    end
                end
            end
            tkhq_pkg::S_RD_WAIT: begin
                state_next = tkhq_pkg::S_RESULT;
            end
            tkhq_pkg::S_ROOT: begin
                state_next = (mv_score_reg < rd_score) ? tkhq_pkg::S_RESULT
                                                       : tkhq_pkg::S_UP_RD;
            end
            tkhq_pkg::S_UP_RD: begin
                state_next = (cur_reg == '0) ? tkhq_pkg::S_UP_DONE : tkhq_pkg::S_UP_CMP;
            end
            tkhq_pkg::S_UP_CMP: begin
                state_next = (mv_score_reg < rd_score) ? tkhq_pkg::S_UP_RD
                                                       : tkhq_pkg::S_UP_DONE;
            end
            tkhq_pkg::S_UP_DONE: begin
                state_next = (cnt_reg > k_lim) ? tkhq_pkg::S_DN_LOAD : tkhq_pkg::S_RESULT;
            end
            tkhq_pkg::S_DN_LOAD: begin
                state_next = tkhq_pkg::S_DN_RDL;
            end
            tkhq_pkg::S_DN_RDL: begin
                state_next = l_ok ? tkhq_pkg::S_DN_RDR : tkhq_pkg::S_RESULT;
            end
            tkhq_pkg::S_DN_RDR: begin
                state_next = tkhq_pkg::S_DN_CMP;
            end
            tkhq_pkg::S_DN_CMP: begin
                state_next = (sm_score < mv_score_reg) ? tkhq_pkg::S_DN_RDL
                                                       : tkhq_pkg::S_RESULT;
            end
            tkhq_pkg::S_RESULT: begin
                if (res_ready) begin
                    state_next = tkhq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tkhq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        mv_score_next     = mv_score_reg;
        mv_payload_next   = mv_payload_reg;
        left_score_next   = left_score_reg;
        left_payload_next = left_payload_reg;
        cur_next          = cur_reg;
        cnt_next          = cnt_reg;
        stat_next         = stat_reg;
        rscore_next       = rscore_reg;
        rpayload_next     = rpayload_reg;
        ram_we            = 1'b0;
        ram_waddr         = cur_reg;
        ram_wdata         = {mv_score_reg, mv_payload_reg};
        ram_re            = 1'b0;
        ram_raddr         = '0;
        unique case (state_reg)
            tkhq_pkg::S_IDLE: begin
                if (accept) begin
                    mv_score_next   = in_score;
                    mv_payload_next = in_payload;
                    cur_next        = AW'(cnt_eff);
                    rscore_next     = '0;
                    rpayload_next   = '0;
                    if (in_op == tkhq_pkg::OP_READ) begin
                        stat_next = pos_ok ? tkhq_pkg::STAT_READ_OK
                                           : tkhq_pkg::STAT_READ_RANGE;
                        ram_re    = pos_ok;
                        ram_raddr = AW'(in_pos);
                    end else begin
                        stat_next = tkhq_pkg::STAT_KEPT;
                        if (cnt_eff >= k_lim) begin
                            cnt_next = cnt_eff;
                            ram_re   = 1'b1;
                        end else begin
                            cnt_next = cnt_eff + CW'(1);
                        end
                    end
                end
            end
            tkhq_pkg::S_RD_WAIT: begin
                rscore_next   = rd_score;
                rpayload_next = rd_payload;
            end
            tkhq_pkg::S_ROOT: begin
                if (mv_score_reg < rd_score) begin
                    stat_next = tkhq_pkg::STAT_DROPPED;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            tkhq_pkg::S_UP_RD: begin
                if (cur_reg == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = parent_idx;
                end
            end
            tkhq_pkg::S_UP_CMP: begin
                ram_we = 1'b1;
                if (mv_score_reg < rd_score) begin
                    ram_wdata = ram_rdata;
                    cur_next  = parent_idx;
                end
            end
            tkhq_pkg::S_UP_DONE: begin
                if (cnt_reg > k_lim) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(cnt_reg - CW'(1));
                    cnt_next  = cnt_reg - CW'(1);
                end
            end
            tkhq_pkg::S_DN_LOAD: begin
                mv_score_next   = rd_score;
                mv_payload_next = rd_payload;
                cur_next        = '0;
            end
            tkhq_pkg::S_DN_RDL: begin
                if (l_ok) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(l_idx);
                end else begin
                    ram_we = 1'b1;
                end
            end
            tkhq_pkg::S_DN_RDR: begin
                left_score_next   = rd_score;
                left_payload_next = rd_payload;
                ram_re            = r_ok;
                ram_raddr         = AW'(r_idx);
            end
            tkhq_pkg::S_DN_CMP: begin
                ram_we = 1'b1;
                if (sm_score < mv_score_reg) begin
                    ram_wdata = {sm_score, sm_payload};
                    cur_next  = pick_right ? AW'(r_idx) : AW'(l_idx);
                end
            end
            tkhq_pkg::S_RESULT: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tkhq_pkg::S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        mv_score_reg     <= mv_score_next;
        mv_payload_reg   <= mv_payload_next;
        left_score_reg   <= left_score_next;
        left_payload_reg <= left_payload_next;
        cur_reg          <= cur_next;
        stat_reg         <= stat_next;
        rscore_reg       <= rscore_next;
        rpayload_reg     <= rpayload_next;
    end

endmodule
